>>> rtl/dq_pkg.sv
// Package for the double-ended queue: beat types, request and status codes,
// and size defaults. No dependencies.
package dq_pkg;

    // Default number of entries in the ring buffer
    localparam int DEPTH_DEF = 16;

    // Fixed field widths of the beats
    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Input beat
    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] push_value;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_beat;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pop_ok;
    } t_dp_stat;

endpackage

>>> rtl/dq_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write at the address, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dq_datapath.sv
// Datapath of the double-ended queue: request register, head and count,
// ring index arithmetic, entry RAM and result register.
// Depends on dq_pkg and dq_ram.
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  t_in_beat  i_in,
    output t_out_beat o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    t_in_beat                 r_req;
    logic [AW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic signed [DATA_W-1:0] r_pop_value;
    logic [STAT_W-1:0]        r_status, n_status;
    logic [OCC_W-1:0]         r_occ;

    logic                     full, empty, is_pop, pop_ok;
    logic [SW-1:0]            rear_sum, rear_wrap;
    logic [AW-1:0]            front_dec, front_inc, slot;
    logic                     ram_we;
    logic [DATA_W-1:0]        ram_rdata;

    assign full   = (r_count == DEPTH_C);
    assign empty  = (r_count == '0);
    assign is_pop = r_req.req_type[1];
    assign pop_ok = is_pop && !empty;

    // Ring indices: slot after the rear on push, the rear itself on pop
    always_comb begin
        front_dec = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
        front_inc = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
        rear_sum  = SW'(r_head) + SW'(r_count);
        if (r_req.req_type == REQ_POP_REAR) begin
            rear_sum = rear_sum - SW'(1);
        end
        rear_wrap = (rear_sum >= DEPTH_S) ? rear_sum - DEPTH_S : rear_sum;
    end

    // Select the entry, next head, next count and status
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = STAT_OK;
        slot     = AW'(rear_wrap);
        ram_we   = 1'b0;
        case (r_req.req_type)
            REQ_PUSH_FRONT: begin
                slot = front_dec;
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_head  = front_dec;
                    n_count = r_count + CW'(1);
                    ram_we  = i_cmd.exec;
                end
            end
            REQ_PUSH_REAR: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    ram_we  = i_cmd.exec;
                end
            end
            REQ_POP_FRONT: begin
                slot = r_head;
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_head  = front_inc;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
        endcase
    end

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (slot),
        .i_wdata (r_req.push_value),
        .o_rdata (ram_rdata)
    );

    // Advance head and count on execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Hold the request and build the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in;
        end
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_occ       <= OCC_W'(n_count);
            r_pop_value <= '0;
        end
        if (i_cmd.load) begin
            r_pop_value <= ram_rdata;
        end
    end

    assign o_stat.pop_ok   = pop_ok;
    assign o_out.pop_value = r_pop_value;
    assign o_out.status    = r_status;
    assign o_out.occupancy = r_occ;

    // Count stays within the ring
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds depth");

    // Head stays a valid index when depth is not a power of two
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_head) < DEPTH_S)
        else $error("head index out of range");

    // A successful request changes the count
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && n_status == STAT_OK) |=> (r_count != $past(r_count)))
        else $error("count did not move on a successful request");

endmodule

>>> rtl/dq_ctrl.sv
// Controller of the double-ended queue: sequences capture, execute,
// read-data load and result handoff. Depends on dq_pkg.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid)   n_state = S_EXEC;
            S_EXEC: n_state = i_stat.pop_ok ? S_LOAD : S_RESP;
            S_LOAD: n_state = S_RESP;
            S_RESP: if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive handshake and datapath commands
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_RESP);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_LOAD);

endmodule

>>> rtl/double_ended_queue_core.sv
// Double-ended queue of signed 32-bit words in a ring buffer of DEPTH
// entries. Each request (push front, push rear, pop front, pop rear) gives
// one result beat with the popped word, a status (ok, empty, full) and the
// occupancy after the request. One request is handled at a time: a push, or
// a pop on an empty queue, passes from the execute state to the result state;
// a successful pop has a load state between them for the registered read of
// the entry RAM. The next request is accepted the cycle after the result
// beat is taken.
// No clearing pass after reset; the queue is empty at once.
// Depends on dq_pkg, dq_ctrl, dq_datapath and dq_ram.
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
